FILE: design/mhpq_pkg.sv
package mhpq_pkg;

	localparam int unsigned CAPACITY_DEF = 127;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Result of the shared compare unit: which candidate should move up.
	typedef enum logic [1:0] {
		PICK_NONE,
		PICK_LEFT,
		PICK_RIGHT
	} pick_t;

	typedef struct packed {
		logic                       action;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  removed_value;
		logic signed [VALUE_W-1:0]  top_value;
		logic [COUNT_W-1:0]         count;
	} rsp_t;

endpackage

FILE: design/mhpq_ram.sv
module mhpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 127,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: design/mhpq_cmp.sv
module mhpq_cmp import mhpq_pkg::*; (
	input  logic signed [VALUE_W-1:0] cur,
	input  logic signed [VALUE_W-1:0] left,
	input  logic signed [VALUE_W-1:0] right,
	input  logic                      left_ok,
	input  logic                      right_ok,
	output pick_t                     pick
);

	logic gt_l;
	logic gt_r;
	logic l_lt_r;

	// The three compares run side by side; on equal candidates the left one wins.
	assign gt_l   = left_ok && (cur < left);
	assign gt_r   = right_ok && (cur < right);
	assign l_lt_r = left < right;

	always_comb begin
		priority if (gt_r && (!gt_l || l_lt_r)) begin
			pick = PICK_RIGHT;
		end else if (gt_l) begin
			pick = PICK_LEFT;
		end else begin
			pick = PICK_NONE;
		end
	end

endmodule

FILE: design/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit values, held in a single RAM with one
// write and two registered read ports, walked by a small sequencer around one shared
// compare unit. Each request item gives exactly one response item. Each heap level that an
// insert climbs or a remove sinks is worked as a read step and then a compare-and-write
// step; a remove first reads the last entry to move it to the root, and a remove on an
// empty heap or an insert on a full one goes straight to the finish step. With the default
// capacity of 127 the heap has seven levels. The request side stalls while an item is being
// worked; a finished response waits in an output register, so the next request can be
// taken while the previous response is still pending.
module max_heap_priority_queue import mhpq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_item,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_item
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_LAST_RD,
		S_LAST_WAIT,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             pos_q;
	logic signed [VALUE_W-1:0] mv_q;
	logic signed [VALUE_W-1:0] top_q;
	logic signed [VALUE_W-1:0] rem_q;
	status_t                   st_q;
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [VALUE_W-1:0]        ram_wdata;
	logic [AW-1:0]             ram_raddr_a;
	logic [AW-1:0]             ram_raddr_b;
	logic [VALUE_W-1:0]        ram_rdata_a;
	logic [VALUE_W-1:0]        ram_rdata_b;

	logic signed [VALUE_W-1:0] cmp_cur;
	logic signed [VALUE_W-1:0] cmp_left;
	logic signed [VALUE_W-1:0] cmp_right;
	logic                      cmp_left_ok;
	logic                      cmp_right_ok;
	pick_t                     cmp_pick;

	logic [CW:0]               lc;
	logic [CW:0]               rc;
	logic [CW:0]               cnt_x;
	logic                      lc_ok;
	logic                      rc_ok;
	logic [CW-1:0]             parent;
	logic [AW-1:0]             pos_addr;
	logic                      req_take;
	logic                      rsp_free;

	assign lc       = {pos_q, 1'b0};
	assign rc       = {pos_q, 1'b1};
	assign cnt_x    = {1'b0, cnt_q};
	assign lc_ok    = lc <= cnt_x;
	assign rc_ok    = rc <= cnt_x;
	assign parent   = pos_q >> 1;
	assign pos_addr = AW'(pos_q - 1'b1);

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	mhpq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	mhpq_cmp u_cmp (
		.cur      (cmp_cur),
		.left     (cmp_left),
		.right    (cmp_right),
		.left_ok  (cmp_left_ok),
		.right_ok (cmp_right_ok),
		.pick     (cmp_pick)
	);

	// Sifting up reuses the unit with the parent as the current entry and the
	// climbing value as the only candidate.
	always_comb begin
		if (state_q == S_UP_CMP) begin
			cmp_cur      = $signed(ram_rdata_a);
			cmp_left     = mv_q;
			cmp_right    = mv_q;
			cmp_left_ok  = 1'b1;
			cmp_right_ok = 1'b0;
		end else begin
			cmp_cur      = mv_q;
			cmp_left     = $signed(ram_rdata_a);
			cmp_right    = $signed(ram_rdata_b);
			cmp_left_ok  = lc_ok;
			cmp_right_ok = rc_ok;
		end
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = pos_addr;
		ram_wdata   = mv_q;
		ram_raddr_a = pos_addr;
		ram_raddr_b = pos_addr;
		unique case (state_q)
			S_UP_RD: begin
				if (pos_q == CW'(1)) begin
					ram_we = 1'b1;
				end
				ram_raddr_a = AW'(parent - 1'b1);
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cmp_pick != PICK_NONE) begin
					ram_wdata = ram_rdata_a;
				end
			end
			S_LAST_RD: begin
				ram_raddr_a = AW'(cnt_q - 1'b1);
			end
			S_DN_RD: begin
				if (!lc_ok) begin
					ram_we = 1'b1;
				end
				ram_raddr_a = AW'(lc - 1'b1);
				ram_raddr_b = AW'(lc);
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				unique case (cmp_pick)
					PICK_LEFT:  ram_wdata = ram_rdata_a;
					PICK_RIGHT: ram_wdata = ram_rdata_b;
					default:    ram_wdata = mv_q;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			// The root is mirrored in a register so the maximum is always at hand.
			if (ram_we && ram_waddr == '0) begin
				top_q <= ram_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (req_item.action == ACT_INSERT) begin
							rem_q <= '0;
							if (cnt_q == CW'(CAPACITY)) begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end else begin
								st_q    <= ST_OK;
								cnt_q   <= cnt_q + 1'b1;
								pos_q   <= cnt_q + 1'b1;
								mv_q    <= req_item.value;
								state_q <= S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								rem_q   <= '0;
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								rem_q   <= top_q;
								st_q    <= ST_OK;
								state_q <= S_LAST_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == CW'(1)) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_pick != PICK_NONE) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LAST_RD: begin
					state_q <= S_LAST_WAIT;
				end
				S_LAST_WAIT: begin
					mv_q    <= $signed(ram_rdata_a);
					cnt_q   <= cnt_q - 1'b1;
					pos_q   <= CW'(1);
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= lc_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					unique case (cmp_pick)
						PICK_LEFT: begin
							pos_q   <= lc[CW-1:0];
							state_q <= S_DN_RD;
						end
						PICK_RIGHT: begin
							pos_q   <= rc[CW-1:0];
							state_q <= S_DN_RD;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_FIN: begin
					if (rsp_free) begin
						rsp_q.status        <= st_q;
						rsp_q.removed_value <= rem_q;
						rsp_q.top_value     <= (cnt_q != '0) ? top_q : '0;
						rsp_q.count         <= COUNT_W'(cnt_q);
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (pos_q != '0) && ((pos_q <= cnt_q) || (cnt_q == '0)))
		else $error("heap write outside the occupied entries");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_FIN)
		else $error("response raised outside the finish step");

endmodule
